// ===== rtl/core/mlqs_pkg.sv =====
// shared types and codes for the multilevel queue slot scheduler
`timescale 1ns / 1ps

package mlqs_pkg;

	// fixed field widths of the transaction payloads
	localparam int KIND_W   = 2;
	localparam int LEVEL_W  = 3;
	localparam int PID_W    = 8;
	localparam int STATUS_W = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPEND = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

	// level picker flags
	typedef struct packed {
		logic any_busy;
		logic refill;
	} pick_t;

endpackage

// ===== rtl/core/multilevel_queue_slot_scheduler.sv =====
// top level of the multilevel queue slot scheduler
//
//  channel | signals                       | direction | handshake
//  --------+-------------------------------+-----------+-----------------------
//  request | kind, level, proc_id          | in        | in_valid / in_ready
//  result  | status, out_id, out_level     | out       | out_valid / out_ready
//
// one transaction per cycle sustained while the result side is not stalled
// the request sits in an input register, level selection, fifo update and memory read
// happen on the edge that moves it into the result register
// reset clears pointers and fill counts and loads every credit at once; no clearing pass
// a stalled result holds the input register, which still frees when the result is taken
`timescale 1ns / 1ps

module multilevel_queue_slot_scheduler
	import mlqs_pkg::*;
#(
	parameter int NUM_PRIO    = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [LEVEL_W-1:0]  level,
	input  logic [PID_W-1:0]    proc_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [PID_W-1:0]    out_id,
	output logic [LEVEL_W-1:0]  out_level
);

	localparam int LVL_W = $clog2(NUM_PRIO);

	logic                 v_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [LEVEL_W-1:0]   level_s1;
	logic [PID_W-1:0]     id_s1;

	logic                 adv_s1;
	logic                 lvl_ok;
	logic [LVL_W-1:0]     lvl_idx;

	logic                 push_en;
	logic                 pop_en;
	logic                 spend_en;
	logic                 refill_en;
	logic                 deq_ok;
	logic [STATUS_W-1:0]  st_d;

	logic [NUM_PRIO-1:0]  busy;
	logic [NUM_PRIO-1:0]  full;
	logic [NUM_PRIO-1:0]  credit_nz;
	logic [NUM_PRIO-1:0]  credit_le1;
	logic [LVL_W-1:0]     sel;
	pick_t                pick;
	logic [ID_BITS-1:0]   rd_id_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 deq_q;
	logic [LEVEL_W-1:0]   olvl_q;

	assign adv_s1   = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	assign lvl_ok  = (32'(level_s1) < 32'(NUM_PRIO));
	assign lvl_idx = LVL_W'(level_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			level_s1 <= level;
			id_s1    <= proc_id;
		end
	end

	mlqs_pick #(
		.NUM_PRIO (NUM_PRIO)
	) u_pick (
		.busy      (busy),
		.credit_nz (credit_nz),
		.sel       (sel),
		.pick      (pick)
	);

	always_comb begin
		push_en   = 1'b0;
		pop_en    = 1'b0;
		spend_en  = 1'b0;
		refill_en = 1'b0;
		deq_ok    = 1'b0;
		st_d      = ST_OK;
		unique case (kind_s1)
			KIND_ENQ: begin
				if (!lvl_ok) begin
					st_d = ST_FULL;
				end else if (full[lvl_idx]) begin
					st_d = ST_FULL;
				end else begin
					push_en = adv_s1;
				end
			end
			KIND_DEQ: begin
				if (!pick.any_busy) begin
					st_d = ST_EMPTY;
				end else begin
					deq_ok    = 1'b1;
					pop_en    = adv_s1;
					refill_en = adv_s1 && pick.refill;
				end
			end
			KIND_SPEND: begin
				if (lvl_ok) begin
					spend_en = adv_s1;
					// credit ends at zero whether it was one or already empty
					if (credit_le1[lvl_idx]) begin
						st_d = ST_EXHAUSTED;
					end
				end
			end
			KIND_NOP: begin
			end
			default: begin
			end
		endcase
	end

	mlqs_fifo #(
		.NUM_PRIO    (NUM_PRIO),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (push_en),
		.push_lvl (lvl_idx),
		.push_id  (ID_BITS'(id_s1)),
		.pop_en   (pop_en),
		.pop_lvl  (sel),
		.rd_id_q  (rd_id_q),
		.busy     (busy),
		.full     (full)
	);

	mlqs_credit #(
		.NUM_PRIO (NUM_PRIO)
	) u_credit (
		.clk        (clk),
		.arst_n     (arst_n),
		.spend_en   (spend_en),
		.spend_lvl  (lvl_idx),
		.refill_en  (refill_en),
		.busy       (busy),
		.credit_nz  (credit_nz),
		.credit_le1 (credit_le1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= st_d;
			deq_q    <= deq_ok;
			olvl_q   <= deq_ok ? LEVEL_W'(sel) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_level = olvl_q;
	// read data register only reloads on a dequeue, so gate it for other results
	assign out_id    = deq_q ? PID_W'(rd_id_q) : '0;

`ifndef ASSERT_OFF
	a_id_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_id != '0) |-> (status == ST_OK))
		else $error("nonzero out_id with a failing status");

	a_level_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY || status == ST_FULL || status == ST_EXHAUSTED))
		|-> (out_level == '0 && out_id == '0))
		else $error("result fields not cleared on a failing status");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("request left the input register without a result");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_en && (pop_en || spend_en)))
		else $error("more than one state update for one transaction");
`endif

endmodule

// ===== rtl/core/mlqs_pick.sv =====
// level picker: first busy level with credit, or first busy level after a refill
`timescale 1ns / 1ps

module mlqs_pick
	import mlqs_pkg::*;
#(
	parameter int NUM_PRIO = 8
) (
	input  logic [NUM_PRIO-1:0]         busy,
	input  logic [NUM_PRIO-1:0]         credit_nz,
	output logic [$clog2(NUM_PRIO)-1:0] sel,
	output pick_t                       pick
);

	localparam int LVL_W = $clog2(NUM_PRIO);

	logic [NUM_PRIO-1:0] elig;
	logic [NUM_PRIO-1:0] cand;

	assign elig = busy & credit_nz;
	// when no busy level has credit, every busy level is refilled and wins on priority
	assign cand = (|elig) ? elig : busy;

	assign pick.any_busy = |busy;
	assign pick.refill   = (|busy) && !(|elig);

	always_comb begin
		sel = '0;
		for (int i = NUM_PRIO - 1; i >= 0; i--) begin
			if (cand[i]) begin
				sel = LVL_W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/mlqs_credit.sv =====
// per-level slot credits with saturating spend and refill of busy levels
`timescale 1ns / 1ps

module mlqs_credit
	import mlqs_pkg::*;
#(
	parameter int NUM_PRIO = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        spend_en,
	input  logic [$clog2(NUM_PRIO)-1:0] spend_lvl,
	input  logic                        refill_en,
	input  logic [NUM_PRIO-1:0]         busy,
	output logic [NUM_PRIO-1:0]         credit_nz,
	output logic [NUM_PRIO-1:0]         credit_le1
);

	localparam int CRED_W = $clog2(NUM_PRIO + 1);

	logic [CRED_W-1:0] cred_q [NUM_PRIO];

	always_comb begin
		for (int l = 0; l < NUM_PRIO; l++) begin
			credit_nz[l]  = (cred_q[l] != '0);
			credit_le1[l] = (cred_q[l] <= CRED_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_PRIO; l++) begin
				cred_q[l] <= CRED_W'(NUM_PRIO - l);
			end
		end else if (refill_en) begin
			for (int l = 0; l < NUM_PRIO; l++) begin
				if (busy[l]) begin
					cred_q[l] <= CRED_W'(NUM_PRIO - l);
				end
			end
		end else if (spend_en && cred_q[spend_lvl] != '0) begin
			cred_q[spend_lvl] <= cred_q[spend_lvl] - CRED_W'(1);
		end
	end

endmodule

// ===== rtl/core/mlqs_fifo.sv =====
// per-level id fifos in one shared memory with head, tail and fill count per level
`timescale 1ns / 1ps

module mlqs_fifo
	import mlqs_pkg::*;
#(
	parameter int NUM_PRIO    = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_en,
	input  logic [$clog2(NUM_PRIO)-1:0] push_lvl,
	input  logic [ID_BITS-1:0]          push_id,
	input  logic                        pop_en,
	input  logic [$clog2(NUM_PRIO)-1:0] pop_lvl,
	output logic [ID_BITS-1:0]          rd_id_q,
	output logic [NUM_PRIO-1:0]         busy,
	output logic [NUM_PRIO-1:0]         full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ID_BITS-1:0] mem [NUM_PRIO][QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_q [NUM_PRIO];
	logic [PTR_W-1:0]   tail_q [NUM_PRIO];
	logic [CNT_W-1:0]   count_q [NUM_PRIO];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		for (int l = 0; l < NUM_PRIO; l++) begin
			busy[l] = (count_q[l] != '0);
			full[l] = (count_q[l] == CNT_W'(QUEUE_DEPTH));
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem[push_lvl][tail_q[push_lvl]] <= push_id;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_en) begin
			rd_id_q <= mem[pop_lvl][head_q[pop_lvl]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_PRIO; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			if (push_en) begin
				tail_q[push_lvl]  <= ptr_inc(tail_q[push_lvl]);
				count_q[push_lvl] <= count_q[push_lvl] + CNT_W'(1);
			end
			if (pop_en) begin
				head_q[pop_lvl]  <= ptr_inc(head_q[pop_lvl]);
				count_q[pop_lvl] <= count_q[pop_lvl] - CNT_W'(1);
			end
		end
	end

endmodule

// ===== tb/multilevel_queue_slot_scheduler_tb.sv =====
// self-checking testbench for the multilevel queue slot scheduler
`timescale 1ns / 1ps

module multilevel_queue_slot_scheduler_tb;
	import mlqs_pkg::*;

	localparam int NUM_LEVELS     = 8;
	localparam int Q_DEPTH        = 16;
	localparam int ID_W           = 8;
	localparam int N_ITEMS        = 1450;
	localparam int TAIL_LEN       = 150;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_LEN       = 60;
	localparam int DRAIN_AT       = 900;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] level;
		logic [PID_W-1:0]   pid;
	} sched_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PID_W-1:0]    id;
		logic [LEVEL_W-1:0]  lvl;
	} sched_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = KIND_NOP;
	logic [LEVEL_W-1:0]  level = '0;
	logic [PID_W-1:0]    proc_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [PID_W-1:0]    out_id;
	logic [LEVEL_W-1:0]  out_level;

	multilevel_queue_slot_scheduler #(
		.NUM_PRIO(NUM_LEVELS),
		.QUEUE_DEPTH(Q_DEPTH),
		.ID_BITS(ID_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.level(level),
		.proc_id(proc_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_id(out_id),
		.out_level(out_level)
	);

	// scheduler shadow state
	logic [PID_W-1:0] lvl_store [NUM_LEVELS][Q_DEPTH];
	int lvl_head   [NUM_LEVELS];
	int lvl_tail   [NUM_LEVELS];
	int lvl_count  [NUM_LEVELS];
	int lvl_credit [NUM_LEVELS];

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int n_accepted = 0;
	int errors = 0;

	function automatic int first_ready_level();
		for (int i = 0; i < NUM_LEVELS; i++)
			if (lvl_count[i] != 0 && lvl_credit[i] != 0)
				return i;
		return -1;
	endfunction

	function automatic sched_res_t predict_schedule(input sched_req_t r);
		sched_res_t res;
		int pick;
		bit busy;
		res = '0;
		res.status = ST_OK;
		case (r.kind)
			KIND_ENQ: begin
				if (r.level >= NUM_LEVELS || lvl_count[r.level] >= Q_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					lvl_store[r.level][lvl_tail[r.level]] = r.pid;
					lvl_tail[r.level] = (lvl_tail[r.level] + 1) % Q_DEPTH;
					lvl_count[r.level]++;
				end
			end
			KIND_DEQ: begin
				busy = 1'b0;
				foreach (lvl_count[i])
					if (lvl_count[i] != 0)
						busy = 1'b1;
				if (!busy) begin
					res.status = ST_EMPTY;
				end else begin
					pick = first_ready_level();
					// every busy level out of credit: refill busy levels and pick again
					if (pick < 0) begin
						foreach (lvl_count[i])
							if (lvl_count[i] != 0)
								lvl_credit[i] = NUM_LEVELS - i;
						pick = first_ready_level();
					end
					res.id = lvl_store[pick][lvl_head[pick]];
					res.lvl = LEVEL_W'(pick);
					lvl_head[pick] = (lvl_head[pick] + 1) % Q_DEPTH;
					lvl_count[pick]--;
				end
			end
			KIND_SPEND: begin
				if (r.level < NUM_LEVELS) begin
					if (lvl_credit[r.level] > 0)
						lvl_credit[r.level]--;
					if (lvl_credit[r.level] == 0)
						res.status = ST_EXHAUSTED;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic queue_req(input logic [KIND_W-1:0] k, input int lv, input int pid);
		sched_req_t r;
		r.kind = k;
		r.level = LEVEL_W'(lv);
		r.pid = PID_W'(pid);
		pending_reqs.push_back(r);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// stimulus, reset and end of run
	initial begin
		int chunk_len, lo, hi, enq_pct, spend_pct, roll, lv, pid;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_head[i] = 0;
			lvl_tail[i] = 0;
			lvl_count[i] = 0;
			lvl_credit[i] = NUM_LEVELS - i;
		end

		queue_req(KIND_DEQ, 0, 8'hFF);     // everything empty
		queue_req(KIND_SPEND, 7, 0);       // last credit of level 7 gone
		queue_req(KIND_SPEND, 7, 0);       // spend with credit already at zero
		queue_req(KIND_SPEND, 0, 0);
		queue_req(KIND_NOP, 7, 8'hFF);
		queue_req(KIND_ENQ, 0, 8'hFF);
		queue_req(KIND_ENQ, 7, 8'h00);
		// fill level 5, the last one is dropped
		for (int i = 0; i <= Q_DEPTH; i++)
			queue_req(KIND_ENQ, 5, (i % 2) ? 8'hA5 ^ i : 8'h5A ^ i);
		queue_req(KIND_DEQ, 0, 0);

		// random chunks with a narrow or wide level window and a shifting mix
		while (pending_reqs.size() < N_ITEMS) begin
			chunk_len = $urandom_range(20, 60);
			lo = $urandom_range(0, NUM_LEVELS - 1);
			hi = ($urandom_range(0, 2) == 0) ? NUM_LEVELS - 1 :
				((lo + 1 < NUM_LEVELS) ? lo + 1 : lo);
			enq_pct = $urandom_range(25, 65);
			spend_pct = $urandom_range(5, 25);
			for (int i = 0; i < chunk_len; i++) begin
				roll = $urandom_range(0, 99);
				lv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_LEVELS - 1) :
					$urandom_range(lo, hi);
				case ($urandom_range(0, 9))
					0: pid = 0;
					1: pid = 255;
					default: pid = $urandom_range(0, 255);
				endcase
				if (roll < enq_pct)
					queue_req(KIND_ENQ, lv, pid);
				else if (roll < enq_pct + spend_pct)
					queue_req(KIND_SPEND, lv, pid);
				else if (roll < enq_pct + spend_pct + 5)
					queue_req(KIND_NOP, lv, pid);
				else
					queue_req(KIND_DEQ, lv, pid);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// driver
	int src_gap;
	bit drained;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_NOP;
			level <= '0;
			proc_id <= '0;
			src_gap = 0;
			drained = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_schedule('{kind, level, proc_id}));
				n_accepted++;
			end
			if (in_valid && !in_ready) begin
				// transaction still waiting, hold it
			end else if (!drained && n_accepted >= DRAIN_AT) begin
				in_valid <= 1'b0;
				if (expected_results.size() == 0)
					drained = 1'b1;
			end else if (src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap--;
			end else if (pending_reqs.size() >= TAIL_LEN && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				src_gap = $urandom_range(0, 5);
			end else if (pending_reqs.size() != 0) begin
				in_valid <= 1'b1;
				kind <= pending_reqs[0].kind;
				level <= pending_reqs[0].level;
				proc_id <= pending_reqs[0].pid;
				void'(pending_reqs.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and result-side back-pressure
	int sink_gap;
	int hold_cnt;
	bit held;
	always @(posedge clk or negedge arst_n) begin
		sched_res_t exp_res;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap = 0;
			hold_cnt = 0;
			held = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected none, actual status %0d id %0d level %0d",
						$time, status, out_id, out_level);
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					if (status !== exp_res.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, exp_res.status, status);
						errors++;
					end
					if (out_id !== exp_res.id) begin
						$display("%0t: out_id mismatch, expected %0d, actual %0d",
							$time, exp_res.id, out_id);
						errors++;
					end
					if (out_level !== exp_res.lvl) begin
						$display("%0t: out_level mismatch, expected %0d, actual %0d",
							$time, exp_res.lvl, out_level);
						errors++;
					end
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (!held && n_accepted >= HOLD_AT) begin
				out_ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= HOLD_LEN)
					held = 1'b1;
			end else if (sink_gap > 0) begin
				out_ready <= 1'b0;
				sink_gap--;
			end else if (pending_reqs.size() >= TAIL_LEN && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				sink_gap = $urandom_range(0, 5);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("FAILURE");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule

// ===== multilevel_queue_slot_scheduler.f =====
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_pick.sv
rtl/core/mlqs_credit.sv
rtl/core/mlqs_fifo.sv
rtl/core/multilevel_queue_slot_scheduler.sv
tb/multilevel_queue_slot_scheduler_tb.sv
